### sv/hgcd_pkg.sv
// ---------------------------------------------------------------------------
// hgcd_pkg: shared constants for the haversine distance unit
// Field widths, fixed-point constants, CORDIC arctangent table and
// register indexes used by the datapath, its sub-units and the checker.
// ---------------------------------------------------------------------------
`default_nettype none

package hgcd_pkg;

  // Field widths
  localparam int LAT_W   = 24;
  localparam int LON_W   = 25;
  localparam int DIST_W  = 31;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Internal widths
  localparam int DEG_W   = 26;  // angle difference, Q16 degrees
  localparam int MAG_W   = 25;  // magnitude of a difference
  localparam int BANG_W  = 32;  // binary angle, 2^32 per turn
  localparam int Q30_W   = 33;  // signed Q30 cosine / haversine values
  localparam int VEC_W   = 34;  // vectoring x / y
  localparam int SQRT_W  = 61;  // radicand, up to 2^60
  localparam int ROOT_W  = 31;  // root, up to 2^30

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;

  // Pipeline depth from request to result strobe, in clock edges
  localparam int HGCD_LATENCY = 110;

  // Saturation limits, Q16 degrees
  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_LIMIT = 25'sd11796480;

  // ceil(2^32 / 45): exact quotient by 45 for operands below 2^28
  localparam logic [26:0] RECIP45 = 27'd95443718;

  localparam logic signed [Q30_W-1:0] ONE_Q30     = 33'sd1073741824;
  localparam logic signed [Q30_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // 4*pi*6371*65536 = 2^32 + DIST_K_LO
  localparam logic [29:0] DIST_K_LO = 30'd951867617;

  // atan(2^-i) in binary-angle units
  localparam logic signed [Q30_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10680094,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81,
    33'sd41,        33'sd20,        33'sd10,        33'sd5,
    33'sd3,         33'sd1
  };

  // Register indexes (taken from paddr[2])
  localparam logic REG_REF_LAT = 1'b0;
  localparam logic REG_REF_LON = 1'b1;

endpackage

`default_nettype wire

### sv/hgcd_cordic.sv
// ---------------------------------------------------------------------------
// hgcd_cordic: pipelined CORDIC cosine
// Folds a binary angle into 0..quarter turn, runs one rotation step per
// stage and restores the sign. 33 stages from request to result.
// ---------------------------------------------------------------------------
`default_nettype none

module hgcd_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic [hgcd_pkg::BANG_W-1:0]        in_angle,
  output logic                               out_vld,
  output logic signed [hgcd_pkg::Q30_W-1:0]  out_cos
);
  import hgcd_pkg::*;

  logic                       fold_vld_r;
  logic [BANG_W-1:0]          fold_r;
  logic [CORDIC_STEPS:0]      vld_r;
  logic signed [Q30_W-1:0]    x_r   [CORDIC_STEPS+1];
  logic signed [Q30_W-1:0]    y_r   [CORDIC_STEPS+1];
  logic signed [Q30_W-1:0]    z_r   [CORDIC_STEPS+1];
  logic                       neg_r [CORDIC_STEPS+1];
  logic                       out_vld_r;
  logic signed [Q30_W-1:0]    cos_r;

  // Symmetry about zero: cos(-a) = cos(a)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
    end else begin
      fold_vld_r <= in_vld;
    end
    fold_r <= in_angle[BANG_W-1] ? (BANG_W'(0) - in_angle) : in_angle;
  end

  // Second quadrant: cos(a) = -cos(half turn - a)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= fold_vld_r;
    end
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    if (fold_r > 32'h4000_0000) begin
      z_r[0]   <= $signed({1'b0, 32'h8000_0000 - fold_r});
      neg_r[0] <= 1'b1;
    end else begin
      z_r[0]   <= $signed({1'b0, fold_r});
      neg_r[0] <= 1'b0;
    end
  end

  // One rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [Q30_W-1:0] xs;
    logic signed [Q30_W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - ATAN_TAB[i];
      end else begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + ATAN_TAB[i];
      end
    end
  end

  // Sign restore
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[CORDIC_STEPS];
    end
    cos_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  end

  assign out_vld = out_vld_r;
  assign out_cos = cos_r;

endmodule

`default_nettype wire

### sv/hgcd_isqrt.sv
// ---------------------------------------------------------------------------
// hgcd_isqrt: pipelined integer square root
// Digit-by-digit root of a radicand up to 2^60, one result bit per stage.
// 32 stages from request to result.
// ---------------------------------------------------------------------------
`default_nettype none

module hgcd_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [hgcd_pkg::SQRT_W-1:0]   in_radicand,
  output logic                          out_vld,
  output logic [hgcd_pkg::ROOT_W-1:0]   out_root
);
  import hgcd_pkg::*;

  logic [SQRT_STEPS:0] vld_r;
  logic [SQRT_W-1:0]   n_r [SQRT_STEPS+1];
  logic [SQRT_W-1:0]   r_r [SQRT_STEPS+1];

  // Input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    n_r[0] <= in_radicand;
    r_r[0] <= '0;
  end

  // Trial subtract per stage, weight falls by four each time
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_digit
    localparam logic [SQRT_W-1:0] WEIGHT = SQRT_W'(1) << (SQRT_W - 1 - 2*k);
    logic [SQRT_W-1:0] trial;
    assign trial = r_r[k] + WEIGHT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      if (n_r[k] >= trial) begin
        n_r[k+1] <= n_r[k] - trial;
        r_r[k+1] <= (r_r[k] >> 1) + WEIGHT;
      end else begin
        n_r[k+1] <= n_r[k];
        r_r[k+1] <= r_r[k] >> 1;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS];
  assign out_root = r_r[SQRT_STEPS][ROOT_W-1:0];

endmodule

`default_nettype wire

### sv/haversine_great_circle_distance_unit.sv
// ---------------------------------------------------------------------------
// haversine_great_circle_distance_unit: great-circle distance pipeline
// Distance in km (Q16) from a query point to a reference point, both in
// Q16 degrees, by the haversine formula with a 6371 km earth radius.
//
//   channel   handshake                 payload
//   request   start / busy              in_point_latitude, in_point_longitude
//   result    out_strobe (one cycle)    out_distance_km
//   config    APB psel/penable/pready   ref_latitude @0x0, ref_longitude @0x4
//
// One request per clock while busy is low; the pipeline depth is mostly set by
// two 30-step CORDIC pipelines and a 31-step square root. busy is high during
// reset and in the cycle after it; it never rises otherwise. Synchronous
// active-low reset clears the valid bits and loads the reference registers with
// their default point. The result side cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module haversine_great_circle_distance_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hgcd_pkg::LAT_W-1:0]   in_point_latitude,
  input  logic signed [hgcd_pkg::LON_W-1:0]   in_point_longitude,
  output logic                                out_strobe,
  output logic [hgcd_pkg::DIST_W-1:0]         out_distance_km,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hgcd_pkg::PADDR_W-1:0]        paddr,
  input  logic [hgcd_pkg::PDATA_W-1:0]        pwdata,
  output logic [hgcd_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import hgcd_pkg::*;

  // Configuration registers
  logic signed [LAT_W-1:0] ref_lat_r;
  logic signed [LON_W-1:0] ref_lon_r;
  logic                    busy_r;
  logic                    accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= -24'sd1305654;
      ref_lon_r <= -25'sd2879986;
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_REF_LAT: ref_lat_r <= $signed(pwdata[LAT_W-1:0]);
          REG_REF_LON: ref_lon_r <= $signed(pwdata[LON_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_REF_LAT: prdata = PDATA_W'(ref_lat_r);
      REG_REF_LON: prdata = PDATA_W'(ref_lon_r);
      default:     prdata = '0;
    endcase
  end

  // Request capture
  logic                    v0_r;
  logic signed [LAT_W-1:0] lat1_r;
  logic signed [LON_W-1:0] lon1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    lat1_r <= in_point_latitude;
    lon1_r <= in_point_longitude;
  end

  // Saturate coordinates
  logic                    v1_r;
  logic signed [LAT_W-1:0] clat1_r, clat2_r;
  logic signed [LON_W-1:0] clon1_r, clon2_r;
  logic signed [LAT_W-1:0] clat1, clat2;
  logic signed [LON_W-1:0] clon1, clon2;

  always_comb begin
    clat1 = lat1_r;
    if (lat1_r > LAT_LIMIT) clat1 = LAT_LIMIT;
    else if (lat1_r < -LAT_LIMIT) clat1 = -LAT_LIMIT;
    clat2 = ref_lat_r;
    if (ref_lat_r > LAT_LIMIT) clat2 = LAT_LIMIT;
    else if (ref_lat_r < -LAT_LIMIT) clat2 = -LAT_LIMIT;
    clon1 = lon1_r;
    if (lon1_r > LON_LIMIT) clon1 = LON_LIMIT;
    else if (lon1_r < -LON_LIMIT) clon1 = -LON_LIMIT;
    clon2 = ref_lon_r;
    if (ref_lon_r > LON_LIMIT) clon2 = LON_LIMIT;
    else if (ref_lon_r < -LON_LIMIT) clon2 = -LON_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    clat1_r <= clat1;
    clat2_r <= clat2;
    clon1_r <= clon1;
    clon2_r <= clon2;
  end

  // Four angles: lat1, lat2, dlat, dlon
  logic                    v2_r;
  logic signed [DEG_W-1:0] d_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    d_r[0] <= DEG_W'(clat1_r);
    d_r[1] <= DEG_W'(clat2_r);
    d_r[2] <= DEG_W'(clat2_r) - DEG_W'(clat1_r);
    d_r[3] <= DEG_W'(clon2_r) - DEG_W'(clon1_r);
  end

  // Degrees to binary angle: round(|d| * 65536 / 360), sign restored.
  // Quotient split as |d| = 45u + v, so q = u*8192 + (v*8192 + 22) / 45.
  logic v3_r, v4_r, v5_r, v6_r, v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  logic [BANG_W-1:0] bang_r [4];

  for (genvar j = 0; j < 4; j++) begin : g_bang
    logic              sgn3_r, sgn4_r, sgn5_r, sgn6_r;
    logic [MAG_W-1:0]  mag3_r, mag4_r;
    logic [19:0]       u4_r, u5_r, u6_r;
    logic [18:0]       w5_r;
    logic [12:0]       q6_r;
    logic [51:0]       um;
    logic [MAG_W-1:0]  v_full;
    logic [45:0]       wm;
    logic [32:0]       q;

    assign um     = 52'(mag3_r) * 52'(RECIP45);
    assign v_full = mag4_r - (MAG_W'(u4_r) * MAG_W'(45));
    assign wm     = 46'(w5_r) * 46'(RECIP45);
    assign q      = {u6_r, q6_r};

    always_ff @(posedge clk) begin
      // sign and magnitude
      sgn3_r <= d_r[j][DEG_W-1];
      mag3_r <= d_r[j][DEG_W-1] ? MAG_W'(-d_r[j]) : MAG_W'(d_r[j]);
      // coarse quotient
      sgn4_r <= sgn3_r;
      mag4_r <= mag3_r;
      u4_r   <= um[51:32];
      // remainder scaled
      sgn5_r <= sgn4_r;
      u5_r   <= u4_r;
      w5_r   <= {v_full[5:0], 13'd0} + 19'd22;
      // fine quotient
      sgn6_r <= sgn5_r;
      u6_r   <= u5_r;
      q6_r   <= wm[44:32];
      // wrap to one turn
      bang_r[j] <= sgn6_r ? (BANG_W'(0) - q[BANG_W-1:0]) : q[BANG_W-1:0];
    end
  end

  // Cosines
  logic [3:0]              cos_vld;
  logic signed [Q30_W-1:0] cos_q [4];

  for (genvar j = 0; j < 4; j++) begin : g_cos
    hgcd_cordic u_cordic (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (v7_r),
      .in_angle (bang_r[j]),
      .out_vld  (cos_vld[j]),
      .out_cos  (cos_q[j])
    );
  end

  // Haversine term
  logic                    h1_vld_r, h2_vld_r, h3_vld_r, h4_vld_r;
  logic signed [62:0]      prod_r;
  logic signed [Q30_W-1:0] hlat1_r, hlon1_r, hlat2_r, hlon2_r, hlat3_r;
  logic signed [Q30_W-1:0] p_r;
  logic signed [63:0]      ph_r;
  logic [ROOT_W-1:0]       a_r;
  logic signed [65:0]      cc_full;
  logic signed [62:0]      p_round;
  logic signed [65:0]      ph_full;
  logic signed [63:0]      a_sum;
  logic signed [32:0]      a_raw;

  assign cc_full = cos_q[0] * cos_q[1];
  assign p_round = prod_r + 63'sd536870912;
  assign ph_full = p_r * hlon2_r;
  assign a_sum   = $signed({hlat3_r[Q30_W-1], hlat3_r, 30'd0}) + ph_r + 64'sd1073741824;
  assign a_raw   = a_sum[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
      h2_vld_r <= 1'b0;
      h3_vld_r <= 1'b0;
      h4_vld_r <= 1'b0;
    end else begin
      h1_vld_r <= &cos_vld;
      h2_vld_r <= h1_vld_r;
      h3_vld_r <= h2_vld_r;
      h4_vld_r <= h3_vld_r;
    end
    // cos lat1 * cos lat2, 1 - cos dlat, 1 - cos dlon
    prod_r  <= cc_full[62:0];
    hlat1_r <= ONE_Q30 - cos_q[2];
    hlon1_r <= ONE_Q30 - cos_q[3];
    // round the product to Q30
    p_r     <= p_round[62:30];
    hlat2_r <= hlat1_r;
    hlon2_r <= hlon1_r;
    // weight the longitude term
    ph_r    <= ph_full[63:0];
    hlat3_r <= hlat2_r;
    // halve, round and clamp to 0..1
    if (a_raw < 0) begin
      a_r <= '0;
    end else if (a_raw > ONE_Q30) begin
      a_r <= 31'h4000_0000;
    end else begin
      a_r <= a_raw[ROOT_W-1:0];
    end
  end

  // sqrt(a) and sqrt(1 - a), Q30
  logic              sy_vld, sx_vld;
  logic [ROOT_W-1:0] sy_root, sx_root;

  hgcd_isqrt u_sqrt_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (h4_vld_r),
    .in_radicand ({a_r, 30'd0}),
    .out_vld     (sy_vld),
    .out_root    (sy_root)
  );

  hgcd_isqrt u_sqrt_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (h4_vld_r),
    .in_radicand ({31'h4000_0000 - a_r, 30'd0}),
    .out_vld     (sx_vld),
    .out_root    (sx_root)
  );

  // atan2 by CORDIC vectoring, one step per stage
  logic [CORDIC_STEPS-1:0] vv_r;
  logic signed [VEC_W-1:0] vx_r [CORDIC_STEPS];
  logic signed [VEC_W-1:0] vy_r [CORDIC_STEPS];
  logic signed [Q30_W-1:0] vz_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic                    vin;
    logic signed [VEC_W-1:0] xin, yin, xs, ys;
    logic signed [Q30_W-1:0] zin;

    if (i == 0) begin : g_first
      assign vin = sy_vld && sx_vld;
      assign xin = $signed({3'b000, sx_root});
      assign yin = $signed({3'b000, sy_root});
      assign zin = '0;
    end else begin : g_next
      assign vin = vv_r[i-1];
      assign xin = vx_r[i-1];
      assign yin = vy_r[i-1];
      assign zin = vz_r[i-1];
    end

    assign xs = xin >>> i;
    assign ys = yin >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i] <= 1'b0;
      end else begin
        vv_r[i] <= vin;
      end
      if (yin >= 0) begin
        vx_r[i] <= xin + ys;
        vy_r[i] <= yin - xs;
        vz_r[i] <= zin + ATAN_TAB[i];
      end else begin
        vx_r[i] <= xin - ys;
        vy_r[i] <= yin + xs;
        vz_r[i] <= zin - ATAN_TAB[i];
      end
    end
  end

  // Clamp angle, scale to kilometres
  logic                 ang_vld_r, mul_vld_r, out_vld_r;
  logic [ROOT_W-1:0]    ang_r, ang2_r;
  logic [60:0]          pk_r;
  logic [60:0]          pk_round;
  logic [DIST_W-1:0]    dist_r;
  logic signed [Q30_W-1:0] z_end;

  assign z_end    = vz_r[CORDIC_STEPS-1];
  assign pk_round = pk_r + 61'd2147483648;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ang_vld_r <= vv_r[CORDIC_STEPS-1];
      mul_vld_r <= ang_vld_r;
      out_vld_r <= mul_vld_r;
    end
    if (z_end < 0) begin
      ang_r <= '0;
    end else if (z_end > ONE_Q30) begin
      ang_r <= 31'h4000_0000;
    end else begin
      ang_r <= z_end[ROOT_W-1:0];
    end
    // angle * (4*pi*R*65536 - 2^32); the 2^32 part is the angle itself
    pk_r   <= 61'(ang_r) * 61'(DIST_K_LO);
    ang2_r <= ang_r;
    dist_r <= ang2_r + DIST_W'(pk_round[60:32]);
  end

  assign out_strobe      = out_vld_r;
  assign out_distance_km = dist_r;

endmodule

`default_nettype wire

### sv/hgcd_checker.sv
// ---------------------------------------------------------------------------
// hgcd_checker: port-level checks for the haversine distance unit
// Reset quietness, fixed request-to-result latency and result range.
// ---------------------------------------------------------------------------
`default_nettype none

module hgcd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic [hgcd_pkg::DIST_W-1:0]  out_distance_km
);
  import hgcd_pkg::*;

  // Reset leaves no result in flight and holds requests off
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && busy))
    else $error("result strobe or ready seen straight after reset");

  // Every request gives a result a fixed number of cycles later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##HGCD_LATENCY out_strobe)
    else $error("request gave no result strobe at the pipeline latency");

  // No result strobe without a request the same number of cycles earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, HGCD_LATENCY))
    else $error("result strobe does not match request latency");

  // Distance never exceeds half the earth's circumference
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_distance_km <= 31'd1311800000))
    else $error("distance beyond half circumference");

endmodule

bind haversine_great_circle_distance_unit hgcd_checker u_hgcd_checker (.*);

`default_nettype wire

### dv/haversine_great_circle_distance_unit_test.sv
// ---------------------------------------------------------------------------
// haversine_great_circle_distance_unit_test: self-checking bench
// Drives query points through the request channel and checks every distance
// strobe against a bit-exact integer model of the haversine datapath.
// The reference point is rewritten over APB between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module haversine_great_circle_distance_unit_test;
  import hgcd_pkg::*;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } point_t;

  // Directed requests, run against the default reference point
  localparam int DIR_N = 16;
  localparam point_t DIR_TAB [DIR_N] = '{
    '{24'sd0,          25'sd0},
    '{24'sd5898240,    25'sd11796480},
    '{-24'sd5898240,   -25'sd11796480},
    '{24'sh7fffff,     25'sh0ffffff},       // raw maxima: saturate
    '{24'sh800000,     25'sh1000000},       // raw minima: saturate
    '{24'sd5898241,    25'sd11796481},      // just over the limits
    '{-24'sd5898241,   -25'sd11796481},
    '{-24'sd1305654,   -25'sd2879986},      // the reference point itself
    '{24'sd1305654,    25'sd8916494},       // its antipode
    '{24'sd5898240,    25'sd0},             // north pole
    '{-24'sd5898240,   25'sd0},             // south pole
    '{24'sd0,          25'sd11796480},
    '{24'sd0,          -25'sd11796480},
    '{-24'sd1305654,   -25'sd2879985},      // one LSB away
    '{24'sd1,          -25'sd1},
    '{24'sd2949120,    25'sd5898240}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [LAT_W-1:0] in_point_latitude = '0;
  logic signed [LON_W-1:0] in_point_longitude = '0;
  logic                 out_strobe;
  logic [DIST_W-1:0]    out_distance_km;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Model copy of the reference registers
  longint ref_lat_q16;
  longint ref_lon_q16;

  logic [DIST_W-1:0] dist_due [$];
  int unsigned       fail_count = 0;
  int                send_idle_pct = 0;

  always #2 clk = ~clk;

  haversine_great_circle_distance_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_latitude(in_point_latitude), .in_point_longitude(in_point_longitude),
    .out_strobe(out_strobe), .out_distance_km(out_distance_km),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---- distance model ----

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Q16 degrees to binary angle, half rounded up on the magnitude
  function automatic logic [31:0] deg_to_turns(longint d);
    longint mag;
    logic [31:0] a;
    mag = d < 0 ? -d : d;
    a = 32'((mag * 65536 + 180) / 360);
    if (d < 0) a = -a;
    return a;
  endfunction

  function automatic longint cordic_cosine(longint z);
    longint x, y, xs, ys;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
      end
    end
    return x;
  endfunction

  function automatic longint cosine_of(logic [31:0] a);
    if (a >= 32'h80000000) a = -a;
    if (a > 32'h40000000) return -cordic_cosine(longint'({32'd0, 32'h80000000 - a}));
    return cordic_cosine(longint'({32'd0, a}));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000000000000000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
      end
    end
    return clamp(z, 0, 64'sd1 << 30);
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_km(logic signed [LAT_W-1:0] plat,
                                                        logic signed [LON_W-1:0] plon);
    longint lat1, lon1, lat2, lon2, c1, c2, hlat, hlon, p, a, ang;
    longint unsigned ys, xs, km_q16;
    lat1 = clamp(longint'(plat), -5898240, 5898240);
    lon1 = clamp(longint'(plon), -11796480, 11796480);
    lat2 = clamp(ref_lat_q16, -5898240, 5898240);
    lon2 = clamp(ref_lon_q16, -11796480, 11796480);
    c1 = cosine_of(deg_to_turns(lat1));
    c2 = cosine_of(deg_to_turns(lat2));
    hlat = (64'sd1 << 30) - cosine_of(deg_to_turns(lat2 - lat1));
    hlon = (64'sd1 << 30) - cosine_of(deg_to_turns(lon2 - lon1));
    p = (c1 * c2 + (64'sd1 << 29)) >>> 30;
    a = (hlat * (64'sd1 << 30) + p * hlon + (64'sd1 << 30)) >>> 31;
    a = clamp(a, 0, 64'sd1 << 30);
    ys = int_sqrt(64'(a) << 30);
    xs = int_sqrt(64'((64'sd1 << 30) - a) << 30);
    ang = vector_angle(longint'(xs), longint'(ys));
    km_q16 = (64'(ang) * 64'd5246834913 + (64'd1 << 31)) >> 32;
    return km_q16[DIST_W-1:0];
  endfunction

  // ---- result checker ----

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (dist_due.size() == 0) begin
        $error("distance_km: unexpected result %0d", out_distance_km);
        fail_count++;
      end else begin
        if (out_distance_km !== dist_due[0]) begin
          $error("distance_km: expected %0d, got %0d", dist_due[0], out_distance_km);
          fail_count++;
        end
        void'(dist_due.pop_front());
      end
    end
  end

  // ---- request driving ----

  // Present one request and hold it until taken; start stays high on return unless send_idle_pct drew idle cycles
  task automatic send_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
    start <= 1'b1;
    in_point_latitude <= lat;
    in_point_longitude <= lon;
    do @(posedge clk); while (busy);
    dist_due.push_back(great_circle_km(lat, lon));
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop requesting and let the pipeline empty
  task automatic drain;
    start <= 1'b0;
    while (dist_due.size() != 0) @(posedge clk);
    repeat (HGCD_LATENCY + 10) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_REF_LAT) ref_lat_q16 = longint'(signed'(value[LAT_W-1:0]));
    else ref_lon_q16 = longint'(signed'(value[LON_W-1:0]));
    @(posedge clk);
  endtask

  task automatic set_reference(logic [31:0] lat, logic [31:0] lon);
    reg_write(REG_REF_LAT, lat);
    reg_write(REG_REF_LON, lon);
  endtask

  // Mostly in-range points, some at the limits, some raw bit patterns
  task automatic random_point;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      lat = LAT_W'($urandom_range(2 * 5898240) - 5898240);
      lon = LON_W'($urandom_range(2 * 11796480) - 11796480);
    end else if (pick < 85) begin
      lat = LAT_W'($urandom_range(40) - 20 + ($urandom_range(1) ? 5898240 : -5898240));
      lon = LON_W'($urandom_range(40) - 20 + ($urandom_range(1) ? 11796480 : -11796480));
    end else begin
      lat = LAT_W'($urandom);
      lon = LON_W'($urandom);
    end
    send_point(lat, lon);
  endtask

  // ---- main sequence ----

  initial begin
    ref_lat_q16 = -1305654;
    ref_lon_q16 = -2879986;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points against the default reference
    for (int i = 0; i < DIR_N; i++) send_point(DIR_TAB[i].lat, DIR_TAB[i].lon);
    drain();

    // Extreme reference points, including raw values beyond the limits
    set_reference(32'(5898240), 32'(11796480));
    for (int i = 0; i < 6; i++) send_point(DIR_TAB[i].lat, DIR_TAB[i].lon);
    drain();
    set_reference(32'hff800000, 32'hff000000);
    for (int i = 0; i < 6; i++) send_point(DIR_TAB[i].lat, DIR_TAB[i].lon);
    drain();

    // Random phases, each under a fresh reference point
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: send_idle_pct = 22;
        1: send_idle_pct = 74;
        default: send_idle_pct = 0;
      endcase
      if ($urandom_range(3) == 0)
        set_reference($urandom, $urandom);
      else
        set_reference(32'($urandom_range(2 * 5898240) - 5898240) ^ ($urandom << 24),
                      32'($urandom_range(2 * 11796480) - 11796480) ^ ($urandom << 25));
      for (int n = 0; n < 190; n++) begin
        random_point();
        // Hold off once per phase until the pipeline has emptied
        if (n == 95) begin
          start <= 1'b0;
          while (dist_due.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/hgcd_pkg.sv
sv/hgcd_cordic.sv
sv/hgcd_isqrt.sv
sv/haversine_great_circle_distance_unit.sv
sv/hgcd_checker.sv
dv/haversine_great_circle_distance_unit_test.sv
